[hw/rtl/pcas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcas_pkg: shared types and constants for the subpath closer
// Element codes, coordinate width, the command word that travels from the
// front part to the back part, and the queue status group.
// ----------------------------------------------------------------------------
package pcas_pkg;

  // coordinate width, 16.16 fixed point
  localparam int COORD_WIDTH = 32;
  localparam int CODE_WIDTH  = 3;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  typedef logic [CODE_WIDTH-1:0]         code_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // element codes
  localparam code_t CODE_MOVE      = 3'd0;
  localparam code_t CODE_MOVE_OPEN = 3'd1;
  localparam code_t CODE_LINE      = 3'd2;
  localparam code_t CODE_CURVE     = 3'd3;
  localparam code_t CODE_END       = 3'd4;

  // one classified element: optional closing line, then the main element
  typedef struct packed {
    logic   close;
    coord_t close_x;
    coord_t close_y;
    code_t  code;
    coord_t ctrl1_x;
    coord_t ctrl1_y;
    coord_t ctrl2_x;
    coord_t ctrl2_y;
    coord_t end_x;
    coord_t end_y;
  } cmd_t;

  // queue status seen by both sides
  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

endpackage

[hw/rtl/pcas_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcas_if: element channels of the subpath closer
// Input channel carries one path element per word; output channel carries
// one emitted element per word with a last flag.
// ----------------------------------------------------------------------------
interface pcas_in_if;
  import pcas_pkg::*;

  logic   valid;
  logic   ready;
  code_t  code;
  coord_t ctrl1_x;
  coord_t ctrl1_y;
  coord_t ctrl2_x;
  coord_t ctrl2_y;
  coord_t end_x;
  coord_t end_y;

  modport source (
    output valid, code, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, code, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y,
    output ready
  );
endinterface

interface pcas_out_if;
  import pcas_pkg::*;

  logic   valid;
  logic   ready;
  code_t  out_code;
  coord_t out_ctrl1_x;
  coord_t out_ctrl1_y;
  coord_t out_ctrl2_x;
  coord_t out_ctrl2_y;
  coord_t out_end_x;
  coord_t out_end_y;
  logic   last;

  modport source (
    output valid, out_code, out_ctrl1_x, out_ctrl1_y, out_ctrl2_x, out_ctrl2_y,
           out_end_x, out_end_y, last,
    input  ready
  );
  modport sink (
    input  valid, out_code, out_ctrl1_x, out_ctrl1_y, out_ctrl2_x, out_ctrl2_y,
           out_end_x, out_end_y, last,
    output ready
  );
endinterface

[hw/rtl/path_close_all_subpaths_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_close_all_subpaths_core: subpath closer, top level
// Rewrites a path element stream so that every subpath ends closed.
// ----------------------------------------------------------------------------
// One element word is taken per cycle while the queue has room, and one
// result word leaves per cycle while the output is ready. An element that
// ends an open, unclosed subpath (a move or the end element) gives two
// words, a closing line and then the element, which leave the single output
// register one after the other. In a gapless stream the two-entry command
// queue between the classifier and the emitter sits at one entry, so each
// such element fills it and stalls the input; a gap in the input absorbs it.
// A stalled output also stalls the input once the queue is full. The first
// result word of an element is presented from the output register after the
// element has passed through the command queue.
// Elements with codes 5 to 7 are accepted and dropped without any result.
module path_close_all_subpaths_core (
  input  logic        clk,
  input  logic        rst,
  pcas_in_if.sink     elem_in,
  pcas_out_if.source  elem_out
);
  import pcas_pkg::*;

  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      head;
  q_status_t q_stat;

  // classifier
  pcas_front u_front (
    .clk      (clk),
    .rst      (rst),
    .elem_in  (elem_in),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // command queue
  pcas_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // emitter
  pcas_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .elem_out (elem_out)
  );

  // a word that is not the last of its element is always a closing line
  a_close_is_line: assert property (@(posedge clk) disable iff (rst)
    (elem_out.valid && !elem_out.last) |-> (elem_out.out_code == CODE_LINE))
    else $error("non-final word is not a closing line");

  // the element behind a closing line follows at once and is a move or end
  a_close_then_main: assert property (@(posedge clk) disable iff (rst)
    (elem_out.valid && elem_out.ready && !elem_out.last) |=>
      (elem_out.valid && elem_out.last &&
       (elem_out.out_code == CODE_MOVE || elem_out.out_code == CODE_END)))
    else $error("closing line not followed by its move or end");

  // moves and end carry no control points
  a_move_no_ctrl: assert property (@(posedge clk) disable iff (rst)
    (elem_out.valid &&
     (elem_out.out_code == CODE_MOVE || elem_out.out_code == CODE_END)) |->
      (elem_out.out_ctrl1_x == '0 && elem_out.out_ctrl1_y == '0 &&
       elem_out.out_ctrl2_x == '0 && elem_out.out_ctrl2_y == '0))
    else $error("move or end word with control points");

  // input stalls only on a full queue
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !elem_in.ready |-> q_stat.full)
    else $error("input stalled with room in the queue");

endmodule

[hw/rtl/pcas_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcas_front: element classifier
// Accepts input words, tracks the subpath start, last point and open flag,
// and turns each element with a known code into a command for the back part.
// ----------------------------------------------------------------------------
module pcas_front (
  input  logic                clk,
  input  logic                rst,
  pcas_in_if.sink             elem_in,
  input  pcas_pkg::q_status_t q_stat,
  output logic                push,
  output pcas_pkg::cmd_t      push_cmd
);
  import pcas_pkg::*;

  coord_t start_x;
  coord_t start_y;
  coord_t prev_x;
  coord_t prev_y;
  logic   subpath_open;

  coord_t start_x_next;
  coord_t start_y_next;
  coord_t prev_x_next;
  coord_t prev_y_next;
  logic   subpath_open_next;

  logic accept;
  logic is_move;
  logic is_end;
  logic is_draw;
  logic need_close;

  // take a word whenever the queue has room
  assign elem_in.ready = !q_stat.full;
  assign accept        = elem_in.valid && elem_in.ready;

  // classify the element
  assign is_move = (elem_in.code == CODE_MOVE) || (elem_in.code == CODE_MOVE_OPEN);
  assign is_end  = (elem_in.code == CODE_END);
  assign is_draw = (elem_in.code == CODE_LINE) || (elem_in.code == CODE_CURVE);
  assign need_close = subpath_open && ((prev_x != start_x) || (prev_y != start_y));

  // unknown codes are swallowed without a command
  assign push = accept && (is_move || is_end || is_draw);

  // command word
  always_comb begin
    push_cmd         = '0;
    push_cmd.close_x = start_x;
    push_cmd.close_y = start_y;
    if (is_move) begin
      push_cmd.close = need_close;
      push_cmd.code  = CODE_MOVE;
      push_cmd.end_x = elem_in.end_x;
      push_cmd.end_y = elem_in.end_y;
    end else if (is_end) begin
      push_cmd.close = need_close;
      push_cmd.code  = CODE_END;
    end else begin
      push_cmd.code    = elem_in.code;
      push_cmd.ctrl1_x = elem_in.ctrl1_x;
      push_cmd.ctrl1_y = elem_in.ctrl1_y;
      push_cmd.ctrl2_x = elem_in.ctrl2_x;
      push_cmd.ctrl2_y = elem_in.ctrl2_y;
      push_cmd.end_x   = elem_in.end_x;
      push_cmd.end_y   = elem_in.end_y;
    end
  end

  // subpath state update
  always_comb begin
    start_x_next      = start_x;
    start_y_next      = start_y;
    prev_x_next       = prev_x;
    prev_y_next       = prev_y;
    subpath_open_next = subpath_open;
    if (push) begin
      if (is_move) begin
        start_x_next      = elem_in.end_x;
        start_y_next      = elem_in.end_y;
        prev_x_next       = elem_in.end_x;
        prev_y_next       = elem_in.end_y;
        subpath_open_next = (elem_in.code == CODE_MOVE_OPEN);
      end else if (is_end) begin
        if (need_close) begin
          prev_x_next = start_x;
          prev_y_next = start_y;
        end
        subpath_open_next = 1'b0;
      end else begin
        prev_x_next = elem_in.end_x;
        prev_y_next = elem_in.end_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x      <= '0;
      start_y      <= '0;
      prev_x       <= '0;
      prev_y       <= '0;
      subpath_open <= 1'b0;
    end else begin
      start_x      <= start_x_next;
      start_y      <= start_y_next;
      prev_x       <= prev_x_next;
      prev_y       <= prev_y_next;
      subpath_open <= subpath_open_next;
    end
  end

endmodule

[hw/rtl/pcas_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcas_queue: command queue
// Short first-in first-out store of commands between the classifier and
// the emitter, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module pcas_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pcas_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output pcas_pkg::cmd_t      head,
  output pcas_pkg::q_status_t stat
);
  import pcas_pkg::*;

  cmd_t                  entries [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QCNT_WIDTH-1:0] count;

  logic do_push;
  logic do_pop;

  assign stat.not_empty = (count != '0);
  assign stat.full      = (count == QCNT_WIDTH'(QUEUE_DEPTH));
  assign do_push        = push && !stat.full;
  assign do_pop         = pop && stat.not_empty;
  assign head           = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/pcas_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcas_back: element emitter
// Takes commands from the queue and drives the output register: a closing
// line first where the command asks for one, then the main element.
// ----------------------------------------------------------------------------
module pcas_back (
  input  logic                clk,
  input  logic                rst,
  input  pcas_pkg::cmd_t      head,
  input  pcas_pkg::q_status_t q_stat,
  output logic                pop,
  pcas_out_if.source          elem_out
);
  import pcas_pkg::*;

  logic   out_valid;
  logic   close_done;
  logic   load;
  logic   emit_close;
  code_t  r_code;
  coord_t r_ctrl1_x;
  coord_t r_ctrl1_y;
  coord_t r_ctrl2_x;
  coord_t r_ctrl2_y;
  coord_t r_end_x;
  coord_t r_end_y;
  logic   r_last;

  // output register may take a new word when empty or being drained
  assign load       = !out_valid || elem_out.ready;
  assign emit_close = head.close && !close_done;
  assign pop        = q_stat.not_empty && load && !emit_close;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      close_done <= 1'b0;
    end else if (load) begin
      out_valid  <= q_stat.not_empty;
      if (q_stat.not_empty) begin
        close_done <= emit_close;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && q_stat.not_empty) begin
      if (emit_close) begin
        r_code    <= CODE_LINE;
        r_ctrl1_x <= '0;
        r_ctrl1_y <= '0;
        r_ctrl2_x <= '0;
        r_ctrl2_y <= '0;
        r_end_x   <= head.close_x;
        r_end_y   <= head.close_y;
        r_last    <= 1'b0;
      end else begin
        r_code    <= head.code;
        r_ctrl1_x <= head.ctrl1_x;
        r_ctrl1_y <= head.ctrl1_y;
        r_ctrl2_x <= head.ctrl2_x;
        r_ctrl2_y <= head.ctrl2_y;
        r_end_x   <= head.end_x;
        r_end_y   <= head.end_y;
        r_last    <= 1'b1;
      end
    end
  end

  assign elem_out.valid       = out_valid;
  assign elem_out.out_code    = r_code;
  assign elem_out.out_ctrl1_x = r_ctrl1_x;
  assign elem_out.out_ctrl1_y = r_ctrl1_y;
  assign elem_out.out_ctrl2_x = r_ctrl2_x;
  assign elem_out.out_ctrl2_y = r_ctrl2_y;
  assign elem_out.out_end_x   = r_end_x;
  assign elem_out.out_end_y   = r_end_y;
  assign elem_out.last        = r_last;

endmodule
